[src/bstfi_pkg.sv]
// Shared types and codes for the bucketed sorted table.
package bstfi_pkg;

  localparam logic [1:0] OP_FIND     = 2'd0;
  localparam logic [1:0] OP_FIND_ADD = 2'd1;
  localparam logic [1:0] OP_ADD      = 2'd2;

  localparam logic [1:0] ST_MISS     = 2'd0;
  localparam logic [1:0] ST_HIT      = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  bucket;
    logic [7:0]  key_high;
    logic [63:0] key_low;
    logic [63:0] payload_a;
    logic [63:0] payload_b;
    logic [55:0] payload_c;
  } bstfi_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  position;
    logic [63:0] found_a;
    logic [63:0] found_b;
    logic [55:0] found_c;
  } bstfi_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_SRCH_RD,
    S_SRCH_SL,
    S_SRCH_CMP,
    S_HIT_RD,
    S_HIT_SL,
    S_HIT_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_DONE
  } bstfi_state_t;

endpackage

[src/bstfi_ram.sv]
// Generic single-port RAM with registered read.
module bstfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/bucketed_sorted_table_find_insert.sv]
// Top level of the bucketed sorted table with find and insert.
//
//  channel | ports                          | word
//  input   | in_valid, in_stall, in_data    | bstfi_in_t
//  result  | out_valid, out_stall, out_data | bstfi_out_t
//
// One item at a time: an accept state, a fill read, then per probe an order read,
// a slot read and a compare over about log2(fill)+1 probes, an exit state, a hit
// check of order read, slot read and compare (the compare alone when skipped) and
// a hand-over of the result word. Insert adds an order read and an order write per
// shifted order entry and one write state. After reset a clearing pass zeroes the
// fill RAM, one bucket per cycle, before the first word is accepted.
// A result word waits in the output register while out_stall is high; the next
// item runs meanwhile and waits in its hand-over cycle until the register frees.
module bucketed_sorted_table_find_insert
  import bstfi_pkg::*;
#(
  parameter int BUCKET_BITS    = 8,
  parameter int BUCKET_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  bstfi_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output bstfi_out_t out_data
);

  localparam int NB = 1 << BUCKET_BITS;
  localparam int EB = (BUCKET_ENTRIES > 1) ? $clog2(BUCKET_ENTRIES) : 1;
  localparam int CB = $clog2(BUCKET_ENTRIES + 1);
  localparam int AB = BUCKET_BITS + EB;
  localparam int NS = NB << EB;
  localparam int BW = (BUCKET_BITS < 8) ? BUCKET_BITS : 8;
  localparam int RW = 8 + 64 + 64 + 64 + 56;

  bstfi_state_t state_r, state_nxt;

  bstfi_in_t           req_r;
  logic [BUCKET_BITS-1:0] bkt_r;
  logic [CB-1:0]       fill_r, first_r, count_r, step_r, idx_r;
  logic [BUCKET_BITS-1:0] clr_r;
  logic                clr_done_r;
  logic                out_valid_r;
  bstfi_out_t          out_r;
  bstfi_out_t          res_r;

  logic                   fill_we;
  logic [BUCKET_BITS-1:0] fill_addr;
  logic [CB-1:0]          fill_wdata, fill_rdata;
  logic                   ord_we;
  logic [AB-1:0]          ord_addr;
  logic [EB-1:0]          ord_wdata, ord_rdata;
  logic                   rec_we;
  logic [AB-1:0]          rec_addr;
  logic [RW-1:0]          rec_wdata, rec_rdata;

  logic [7:0]  rd_kh;
  logic [63:0] rd_kl;
  logic        rd_less, rd_eq, can_ins;
  logic [CB-1:0] half;
  logic hit_now;
  logic ins_now;
  logic [BUCKET_BITS-1:0] in_bkt;

  bstfi_ram #(.WIDTH(CB), .DEPTH(NB)) u_fill (
    .clk(clk), .we(fill_we), .addr(fill_addr), .wdata(fill_wdata), .rdata(fill_rdata)
  );
  bstfi_ram #(.WIDTH(EB), .DEPTH(NS)) u_order (
    .clk(clk), .we(ord_we), .addr(ord_addr), .wdata(ord_wdata), .rdata(ord_rdata)
  );
  bstfi_ram #(.WIDTH(RW), .DEPTH(NS)) u_rec (
    .clk(clk), .we(rec_we), .addr(rec_addr), .wdata(rec_wdata), .rdata(rec_rdata)
  );

  assign in_bkt  = BUCKET_BITS'(in_data.bucket[BW-1:0]);
  assign rd_kh   = rec_rdata[RW-1 -: 8];
  assign rd_kl   = rec_rdata[RW-9 -: 64];
  assign rd_less = (rd_kh != req_r.key_high) ? (rd_kh < req_r.key_high)
                                             : (rd_kl < req_r.key_low);
  assign rd_eq   = (rd_kh == req_r.key_high) && (rd_kl == req_r.key_low);
  assign can_ins = (fill_r < CB'(BUCKET_ENTRIES));
  assign half    = count_r >> 1;

  assign hit_now = (req_r.op != OP_ADD) && (first_r < fill_r) && rd_eq;
  assign ins_now = !hit_now && (req_r.op == OP_FIND_ADD || req_r.op == OP_ADD) && can_ins;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (clr_done_r && in_valid) state_nxt = S_FILL;
      end
      S_FILL:     state_nxt = S_SRCH_RD;
      S_SRCH_RD: begin
        if (count_r == '0) begin
          state_nxt = (req_r.op != OP_ADD && first_r < fill_r) ? S_HIT_RD : S_HIT_CMP;
        end else begin
          state_nxt = S_SRCH_SL;
        end
      end
      S_SRCH_SL:  state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = S_SRCH_RD;
      S_HIT_RD:   state_nxt = S_HIT_SL;
      S_HIT_SL:   state_nxt = S_HIT_CMP;
      S_HIT_CMP: begin
        if (ins_now) begin
          state_nxt = (fill_r == first_r) ? S_INSERT : S_SHIFT_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = (idx_r - 1'b1 > first_r) ? S_SHIFT_RD : S_INSERT;
      S_INSERT:   state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    fill_we    = 1'b0;
    fill_addr  = bkt_r;
    fill_wdata = fill_r + 1'b1;
    ord_we     = 1'b0;
    ord_addr   = {bkt_r, idx_r[EB-1:0]};
    ord_wdata  = ord_rdata;
    rec_we     = 1'b0;
    rec_addr   = {bkt_r, ord_rdata};
    rec_wdata  = {req_r.key_high, req_r.key_low, req_r.payload_a, req_r.payload_b,
                  req_r.payload_c};
    unique case (state_r)
      S_IDLE: begin
        fill_addr = clr_done_r ? in_bkt : clr_r;
        fill_we   = !clr_done_r;
        fill_wdata = '0;
      end
      S_SRCH_RD:  ord_addr = {bkt_r, EB'(first_r + half)};
      S_HIT_RD:   ord_addr = {bkt_r, first_r[EB-1:0]};
      S_SHIFT_RD: ord_addr = {bkt_r, EB'(idx_r - 1'b1)};
      S_SHIFT_WR: ord_we   = 1'b1;
      S_INSERT: begin
        ord_we    = 1'b1;
        ord_addr  = {bkt_r, first_r[EB-1:0]};
        ord_wdata = fill_r[EB-1:0];
        rec_we    = 1'b1;
        rec_addr  = {bkt_r, fill_r[EB-1:0]};
        fill_we   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_r       <= '0;
      clr_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!clr_done_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == BUCKET_BITS'(NB - 1)) clr_done_r <= 1'b1;
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)                     out_valid_r <= 1'b0;
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        req_r   <= in_data;
        bkt_r   <= in_bkt;
        first_r <= '0;
      end
      S_FILL: begin
        fill_r  <= (fill_rdata > CB'(BUCKET_ENTRIES)) ? CB'(BUCKET_ENTRIES) : fill_rdata;
        count_r <= (fill_rdata > CB'(BUCKET_ENTRIES)) ? CB'(BUCKET_ENTRIES) : fill_rdata;
      end
      S_SRCH_RD:  step_r <= half;
      S_SRCH_CMP: begin
        if (rd_less) begin
          first_r <= first_r + step_r + 1'b1;
          count_r <= count_r - step_r - 1'b1;
        end else begin
          count_r <= step_r;
        end
      end
      S_HIT_CMP: begin
        idx_r             <= fill_r;
        res_r.position    <= 5'(first_r);
        res_r.found_a     <= hit_now ? rec_rdata[183:120] : '0;
        res_r.found_b     <= hit_now ? rec_rdata[119:56]  : '0;
        res_r.found_c     <= hit_now ? rec_rdata[55:0]    : '0;
        if (hit_now)                                     res_r.status <= ST_HIT;
        else if (ins_now)                                res_r.status <= ST_INSERTED;
        else if (req_r.op == OP_FIND_ADD || req_r.op == OP_ADD) res_r.status <= ST_FULL;
        else                                             res_r.status <= ST_MISS;
      end
      S_SHIFT_WR: idx_r <= idx_r - 1'b1;
      S_DONE: begin
        if (!out_valid_r || !out_stall) out_r <= res_r;
      end
      default: ;
    endcase
  end

  assign in_stall  = !(state_r == S_IDLE && clr_done_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/bstfi_checker.sv]
// Port checker for the bucketed sorted table, bound to the top level.
module bstfi_checker
  import bstfi_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input bstfi_in_t  in_data,
  input logic       out_valid,
  input logic       out_stall,
  input bstfi_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_HIT |-> out_data.found_a == '0
      && out_data.found_b == '0 && out_data.found_c == '0)
    else $error("payload on non-hit");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.position <= 5'd16)
    else $error("position out of range");

endmodule

bind bucketed_sorted_table_find_insert bstfi_checker u_bstfi_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
